@@ design/ces_pkg.sv @@
`timescale 1ns / 1ps
package ces_pkg;
	localparam int TimeBits = 40;
	localparam int MaxRounds = 128;

	typedef struct packed {
		logic [TimeBits-1:0] launch_per;
		logic [TimeBits-1:0] capture_per;
		logic [TimeBits-1:0] launch_at;
		logic [TimeBits-1:0] capture_at;
		logic                analysis_mode;
	} in_word_t;

	typedef struct packed {
		logic signed [TimeBits:0] edge_separation;
		logic                     invalid_period;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GCD_DIV,
		ST_GCD_STEP,
		ST_SEP_DIV,
		ST_DONE
	} back_state_t;
endpackage

@@ design/clock_edge_separation.sv @@
`timescale 1ns / 1ps
// Result valid follows input accept after the Euclidean rounds and the final reduction;
// rounds stop at MAX_ROUNDS.
// A zero period skips the rounds and the reduction.
// The back end takes one word at a time; the front queue takes the next word meanwhile.
// Reset: arst_n clears the queue flag, the sequencer and the output valid.
module clock_edge_separation #(
	parameter int MAX_ROUNDS = ces_pkg::MaxRounds
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ces_pkg::in_word_t in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output ces_pkg::out_word_t out_data
);
	localparam int TIME_BITS = ces_pkg::TimeBits;

	logic qv, qt, qn, qm, qb;
	logic [TIME_BITS-1:0] qd, qr, qf;

	ces_front #(.TIME_BITS(TIME_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.lp(in_data.launch_per[TIME_BITS-1:0]),
		.cp(in_data.capture_per[TIME_BITS-1:0]),
		.le(in_data.launch_at[TIME_BITS-1:0]),
		.ce(in_data.capture_at[TIME_BITS-1:0]),
		.mode(in_data.analysis_mode),
		.q_valid(qv), .q_take(qt), .q_div(qd), .q_rem(qr), .q_diff(qf),
		.q_neg(qn), .q_mode(qm), .q_bad(qb)
	);

	ces_back #(.TIME_BITS(TIME_BITS), .MAX_ROUNDS(MAX_ROUNDS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(qv), .q_take(qt), .q_div(qd),
		.q_rem(qr), .q_diff(qf), .q_neg(qn), .q_mode(qm), .q_bad(qb),
		.out_valid(out_valid), .out_stall(out_stall),
		.sep(out_data.edge_separation), .bad(out_data.invalid_period)
	);
endmodule

@@ design/ces_front.sv @@
`timescale 1ns / 1ps
// Accepts words, classifies them, holds one in a queue register.
module ces_front #(
	parameter int TIME_BITS = ces_pkg::TimeBits
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [TIME_BITS-1:0]   lp,
	input  logic [TIME_BITS-1:0]   cp,
	input  logic [TIME_BITS-1:0]   le,
	input  logic [TIME_BITS-1:0]   ce,
	input  logic                   mode,
	output logic                   q_valid,
	input  logic                   q_take,
	output logic [TIME_BITS-1:0]   q_div,
	output logic [TIME_BITS-1:0]   q_rem,
	output logic [TIME_BITS-1:0]   q_diff,
	output logic                   q_neg,
	output logic                   q_mode,
	output logic                   q_bad
);
	logic full_q;
	assign in_stall = full_q && !q_take;
	assign q_valid  = full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (in_valid && !in_stall) begin
			full_q <= 1'b1;
		end else if (q_take) begin
			full_q <= 1'b0;
		end
	end

	// classify: order periods, fold edge difference to magnitude and sign
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			q_div  <= (lp > cp) ? lp : cp;
			q_rem  <= (lp > cp) ? cp : lp;
			q_neg  <= ce < le;
			q_diff <= (ce >= le) ? ce - le : le - ce;
			q_mode <= mode;
			q_bad  <= (lp == '0) || (cp == '0);
		end
	end
endmodule

@@ design/ces_back.sv @@
`timescale 1ns / 1ps
// Bit-serial remainder unit shared by the Euclidean rounds and final reduction.
module ces_back #(
	parameter int TIME_BITS  = ces_pkg::TimeBits,
	parameter int MAX_ROUNDS = ces_pkg::MaxRounds
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_take,
	input  logic [TIME_BITS-1:0]  q_div,
	input  logic [TIME_BITS-1:0]  q_rem,
	input  logic [TIME_BITS-1:0]  q_diff,
	input  logic                  q_neg,
	input  logic                  q_mode,
	input  logic                  q_bad,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [TIME_BITS:0] sep,
	output logic                  bad
);
	localparam int CntW = $clog2(TIME_BITS + 1);
	localparam int RndW = $clog2(MAX_ROUNDS + 1);

	ces_pkg::back_state_t state_q, state_d;
	logic [TIME_BITS-1:0] div_q, rem_q, diff_q, num_q, r_q;
	logic [CntW-1:0]      bit_q;
	logic [RndW-1:0]      rnd_q;
	logic                 neg_q, mode_q, bad_q, ov_q;
	logic [TIME_BITS:0]   trial;
	logic [TIME_BITS-1:0] other, sepu, rnext;

	assign trial = {r_q, num_q[TIME_BITS-1]};
	assign rnext = (trial >= {1'b0, rem_q}) ? trial[TIME_BITS-1:0] - rem_q
		: trial[TIME_BITS-1:0];
	assign other = rem_q - r_q;

	always_comb begin
		state_d = state_q;
		q_take  = 1'b0;
		unique case (state_q)
			ces_pkg::ST_IDLE: if (q_valid && !ov_q) begin
				q_take = 1'b1;
				state_d = ces_pkg::ST_GCD_STEP;
			end
			ces_pkg::ST_GCD_STEP: begin
				if (bad_q) state_d = ces_pkg::ST_DONE;
				else if (rem_q == '0 || rnd_q == RndW'(MAX_ROUNDS))
					state_d = ces_pkg::ST_SEP_DIV;
				else state_d = ces_pkg::ST_GCD_DIV;
			end
			ces_pkg::ST_GCD_DIV:
				if (bit_q == CntW'(TIME_BITS - 1)) state_d = ces_pkg::ST_GCD_STEP;
			ces_pkg::ST_SEP_DIV:
				if (bit_q == CntW'(TIME_BITS - 1)) state_d = ces_pkg::ST_DONE;
			ces_pkg::ST_DONE: state_d = ces_pkg::ST_IDLE;
			default: state_d = ces_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ces_pkg::ST_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ces_pkg::ST_DONE) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
		end
	end

	assign sepu = r_q;
	always_ff @(posedge clk) begin
		unique case (state_q)
			ces_pkg::ST_IDLE: if (q_take) begin
				div_q <= q_div; rem_q <= q_rem; diff_q <= q_diff;
				neg_q <= q_neg; mode_q <= q_mode; bad_q <= q_bad;
				rnd_q <= '0;
			end
			ces_pkg::ST_GCD_STEP: begin
				// load dividend, clear partial remainder
				bit_q <= '0;
				r_q   <= '0;
				num_q <= (rem_q == '0 || rnd_q == RndW'(MAX_ROUNDS)) ? diff_q : div_q;
				if (rem_q == '0 || rnd_q == RndW'(MAX_ROUNDS)) rem_q <= div_q;
			end
			ces_pkg::ST_GCD_DIV: begin
				r_q   <= rnext;
				num_q <= num_q << 1;
				bit_q <= bit_q + 1'b1;
				if (bit_q == CntW'(TIME_BITS - 1)) begin
					div_q <= rem_q;
					rem_q <= (rnext < rem_q - rnext) ? rnext : rem_q - rnext;
					rnd_q <= rnd_q + 1'b1;
				end
			end
			ces_pkg::ST_SEP_DIV: begin
				r_q   <= rnext;
				num_q <= num_q << 1;
				bit_q <= bit_q + 1'b1;
			end
			ces_pkg::ST_DONE: begin
				// rem_q holds the periods' GCD here, unless MAX_ROUNDS cut the rounds or a period is zero
				bad <= bad_q;
				if (bad_q) sep <= '0;
				else if (r_q == '0) sep <= mode_q ? '0 : {1'b0, rem_q};
				else if (neg_q) sep <= mode_q ? -$signed({1'b0, r_q})
					: $signed({1'b0, rem_q - r_q});
				else sep <= mode_q ? -$signed({1'b0, other}) : $signed({1'b0, sepu});
			end
			default: ;
		endcase
	end

	assign out_valid = ov_q;
endmodule

@@ design/ces_checker.sv @@
`timescale 1ns / 1ps
module ces_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input ces_pkg::in_word_t  in_data,
	input logic               out_valid,
	input logic               out_stall,
	input ces_pkg::out_word_t out_data
);
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_data))
		else $error("input word changed under stall");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result dropped under stall");
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.invalid_period |-> out_data.edge_separation == '0)
		else $error("invalid period with nonzero result");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid)
		else $error("back-to-back results");
endmodule

bind clock_edge_separation ces_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
	.out_data(out_data)
);
